// File: rtl/ifcd_pkg.sv
// Shared types, code points and palette for the IRC format code decoder.
// No dependencies; used by the interfaces and all decoder modules.
package ifcd_pkg;

  localparam int unsigned TEXT_W          = 16;
  localparam int unsigned RGB_W           = 24;
  localparam int unsigned IDX_W           = 7;
  localparam int unsigned PAL_IDX_W       = 4;
  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned STYLE_W         = 6;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [IDX_W-1:0] NO_INDEX = 7'h7F;

  // Control code units
  localparam logic [TEXT_W-1:0] CU_BOLD      = 16'h0002;
  localparam logic [TEXT_W-1:0] CU_COLOR     = 16'h0003;
  localparam logic [TEXT_W-1:0] CU_RESET     = 16'h000F;
  localparam logic [TEXT_W-1:0] CU_MONO      = 16'h0011;
  localparam logic [TEXT_W-1:0] CU_REVERSE   = 16'h0016;
  localparam logic [TEXT_W-1:0] CU_ITALIC    = 16'h001D;
  localparam logic [TEXT_W-1:0] CU_STRIKE    = 16'h001E;
  localparam logic [TEXT_W-1:0] CU_UNDERLINE = 16'h001F;
  localparam logic [TEXT_W-1:0] CU_COMMA     = 16'h002C;
  localparam logic [TEXT_W-1:0] CU_DIGIT_0   = 16'h0030;
  localparam logic [TEXT_W-1:0] CU_DIGIT_9   = 16'h0039;

  // Style flag bit positions
  localparam int unsigned ST_BOLD      = 0;
  localparam int unsigned ST_ITALIC    = 1;
  localparam int unsigned ST_UNDERLINE = 2;
  localparam int unsigned ST_STRIKE    = 3;
  localparam int unsigned ST_MONO      = 4;
  localparam int unsigned ST_REVERSE   = 5;

  typedef enum logic [5:0] {
    PH_PLAIN = 6'b000001,
    PH_START = 6'b000010,
    PH_FG1   = 6'b000100,
    PH_FG2   = 6'b001000,
    PH_COMMA = 6'b010000,
    PH_BG1   = 6'b100000
  } phase_e;

  // One classified unit, handed from the parser to the output stage
  typedef struct packed {
    logic [TEXT_W-1:0]  text_unit;
    logic               is_visible;
    logic               message_done;
    logic [STYLE_W-2:0] style;      // bold..mono, reverse already applied to colors
    logic [IDX_W-1:0]   fg_idx;
    logic [IDX_W-1:0]   bg_idx;
  } unit_t;

  function automatic logic [RGB_W-1:0] palette_rgb(input logic [PAL_IDX_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'hFFFFFF;
      4'd1:  rgb = 24'h000000;
      4'd2:  rgb = 24'h00007F;
      4'd3:  rgb = 24'h009300;
      4'd4:  rgb = 24'hFF0000;
      4'd5:  rgb = 24'h7F0000;
      4'd6:  rgb = 24'h9C009C;
      4'd7:  rgb = 24'hFC7F00;
      4'd8:  rgb = 24'hFFFF00;
      4'd9:  rgb = 24'h00FC00;
      4'd10: rgb = 24'h009393;
      4'd11: rgb = 24'h00FFFF;
      4'd12: rgb = 24'h0000FC;
      4'd13: rgb = 24'hFF00FF;
      4'd14: rgb = 24'h7F7F7F;
      4'd15: rgb = 24'hD2D2D2;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

// File: rtl/ifcd_in_if.sv
// Input channel: one UTF-16 code unit plus end-of-message flag.
// Depends on ifcd_pkg for field widths.
interface ifcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifcd_pkg::TEXT_W-1:0] code_unit;
  logic                        end_of_message;

  modport source(output valid, output code_unit, output end_of_message, input ready);
  modport sink(input valid, input code_unit, input end_of_message, output ready);
endinterface

// File: rtl/ifcd_out_if.sv
// Output channel: decoded unit with style and palette colors.
// Depends on ifcd_pkg for field widths.
interface ifcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [ifcd_pkg::TEXT_W-1:0] text_unit;
  logic                       is_visible;
  logic                       message_done;
  logic                       bold_on;
  logic                       italic_on;
  logic                       underline_on;
  logic                       strike_on;
  logic                       mono_on;
  logic                       fore_valid;
  logic [ifcd_pkg::RGB_W-1:0] fore_rgb;
  logic                       back_valid;
  logic [ifcd_pkg::RGB_W-1:0] back_rgb;

  modport source(output valid, output text_unit, output is_visible, output message_done,
                 output bold_on, output italic_on, output underline_on, output strike_on,
                 output mono_on, output fore_valid, output fore_rgb, output back_valid,
                 output back_rgb, input ready);
  modport sink(input valid, input text_unit, input is_visible, input message_done,
               input bold_on, input italic_on, input underline_on, input strike_on,
               input mono_on, input fore_valid, input fore_rgb, input back_valid,
               input back_rgb, output ready);
endinterface

// File: rtl/ifcd_front.sv
// Front end: accepts code units, runs the format/color parse state and
// classifies each unit. Depends on ifcd_pkg and ifcd_in_if.
module ifcd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ifcd_in_if.sink         in_i,
  input  logic            space_i,
  output logic            push_o,
  output ifcd_pkg::unit_t unit_o
);
  import ifcd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [STYLE_W-1:0] flags_q, flags_d;
  logic [IDX_W-1:0]   fore_q, fore_d, back_q, back_d;
  logic [IDX_W-1:0]   pfore_q, pfore_d, pback_q, pback_d;

  // values after this unit, before the end-of-message reset
  phase_e             phase_n;
  logic [STYLE_W-1:0] flags_n;
  logic [IDX_W-1:0]   fore_n, back_n, pfore_n, pback_n;

  logic               is_digit, is_comma, consumed, visible, commit;
  logic [IDX_W-1:0]   digit;
  logic [IDX_W-1:0]   pfore_x10, pback_x10;
  logic [IDX_W-1:0]   pback_c;

  assign in_i.ready = space_i;
  assign push_o     = in_i.valid && space_i;

  assign is_digit  = (in_i.code_unit >= CU_DIGIT_0) && (in_i.code_unit <= CU_DIGIT_9);
  assign is_comma  = (in_i.code_unit == CU_COMMA);
  assign digit     = {3'b000, in_i.code_unit[3:0]};
  // pending values are single digits here, so x10 + d stays below 100
  assign pfore_x10 = (pfore_q << 3) + (pfore_q << 1) + digit;
  assign pback_x10 = (pback_q << 3) + (pback_q << 1) + digit;

  always_comb begin
    phase_n  = phase_q;
    flags_n  = flags_q;
    fore_n   = fore_q;
    back_n   = back_q;
    pfore_n  = pfore_q;
    pback_n  = pback_q;
    consumed = 1'b0;
    commit   = 1'b0;
    pback_c  = pback_q;

    unique case (phase_q)
      PH_PLAIN: ;
      PH_START: begin
        if (is_digit) begin
          pfore_n  = digit;
          phase_n  = PH_FG1;
          consumed = 1'b1;
        end else begin
          // bare color code clears both colors
          fore_n  = NO_INDEX;
          back_n  = NO_INDEX;
          phase_n = PH_PLAIN;
        end
      end
      PH_FG1: begin
        if (is_digit) begin
          pfore_n  = pfore_x10;
          phase_n  = PH_FG2;
          consumed = 1'b1;
        end else if (is_comma) begin
          phase_n  = PH_COMMA;
          consumed = 1'b1;
        end else begin
          commit = 1'b1;
        end
      end
      PH_FG2: begin
        if (is_comma) begin
          phase_n  = PH_COMMA;
          consumed = 1'b1;
        end else begin
          commit = 1'b1;
        end
      end
      PH_COMMA: begin
        if (is_digit) begin
          pback_n  = digit;
          phase_n  = PH_BG1;
          consumed = 1'b1;
        end else begin
          commit = 1'b1;
        end
      end
      PH_BG1: begin
        commit = 1'b1;
        if (is_digit) begin
          pback_c  = pback_x10;
          consumed = 1'b1;
        end
      end
      default: phase_n = PH_PLAIN;
    endcase

    if (commit) begin
      fore_n = pfore_q;
      if (pback_c != NO_INDEX) begin
        back_n = pback_c;
      end
      phase_n = PH_PLAIN;
      pfore_n = NO_INDEX;
      pback_n = NO_INDEX;
    end

    visible = 1'b0;
    if (!consumed) begin
      unique case (in_i.code_unit)
        CU_BOLD:      flags_n[ST_BOLD]      = ~flags_n[ST_BOLD];
        CU_ITALIC:    flags_n[ST_ITALIC]    = ~flags_n[ST_ITALIC];
        CU_UNDERLINE: flags_n[ST_UNDERLINE] = ~flags_n[ST_UNDERLINE];
        CU_STRIKE:    flags_n[ST_STRIKE]    = ~flags_n[ST_STRIKE];
        CU_MONO:      flags_n[ST_MONO]      = ~flags_n[ST_MONO];
        CU_REVERSE:   flags_n[ST_REVERSE]   = ~flags_n[ST_REVERSE];
        CU_RESET: begin
          flags_n = '0;
          fore_n  = NO_INDEX;
          back_n  = NO_INDEX;
        end
        CU_COLOR: begin
          phase_n = PH_START;
          pfore_n = NO_INDEX;
          pback_n = NO_INDEX;
        end
        default: visible = 1'b1;
      endcase
    end
  end

  always_comb begin
    unit_o              = '0;
    unit_o.message_done = in_i.end_of_message;
    unit_o.fg_idx       = NO_INDEX;
    unit_o.bg_idx       = NO_INDEX;
    if (visible) begin
      unit_o.text_unit  = in_i.code_unit;
      unit_o.is_visible = 1'b1;
      unit_o.style      = flags_n[STYLE_W-2:0];
      unit_o.fg_idx     = flags_n[ST_REVERSE] ? back_n : fore_n;
      unit_o.bg_idx     = flags_n[ST_REVERSE] ? fore_n : back_n;
    end
  end

  always_comb begin
    if (in_i.end_of_message) begin
      phase_d = PH_PLAIN;
      flags_d = '0;
      fore_d  = NO_INDEX;
      back_d  = NO_INDEX;
      pfore_d = NO_INDEX;
      pback_d = NO_INDEX;
    end else begin
      phase_d = phase_n;
      flags_d = flags_n;
      fore_d  = fore_n;
      back_d  = back_n;
      pfore_d = pfore_n;
      pback_d = pback_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      flags_q <= '0;
      fore_q  <= NO_INDEX;
      back_q  <= NO_INDEX;
      pfore_q <= NO_INDEX;
      pback_q <= NO_INDEX;
    end else if (push_o) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      fore_q  <= fore_d;
      back_q  <= back_d;
      pfore_q <= pfore_d;
      pback_q <= pback_d;
    end
  end

endmodule

// File: rtl/ifcd_queue.sv
// Short FIFO of classified units between the parser and the output stage.
// Depends on ifcd_pkg for the unit_t entry type.
module ifcd_queue #(
  parameter int unsigned Depth = ifcd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifcd_pkg::unit_t unit_i,
  output logic            space_o,
  input  logic            pop_i,
  output logic            avail_o,
  output ifcd_pkg::unit_t unit_o
);
  import ifcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  unit_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign space_o = (cnt_q != FullCnt);
  assign avail_o = (cnt_q != '0);
  assign unit_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= unit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/ifcd_back.sv
// Back end: resolves palette colors and holds the result in the output register.
// Depends on ifcd_pkg and ifcd_out_if.
module ifcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  ifcd_pkg::unit_t unit_i,
  output logic            pop_o,
  ifcd_out_if.source      out_o
);
  import ifcd_pkg::*;

  logic             valid_q;
  unit_t            unit_q;
  logic             fg_ok, bg_ok;
  logic [RGB_W-1:0] fg_rgb, bg_rgb;
  logic             fg_ok_q, bg_ok_q;
  logic [RGB_W-1:0] fg_rgb_q, bg_rgb_q;

  assign pop_o = avail_i && (!valid_q || out_o.ready);

  assign fg_ok  = (unit_i.fg_idx < IDX_W'(PALETTE_ENTRIES));
  assign bg_ok  = (unit_i.bg_idx < IDX_W'(PALETTE_ENTRIES));
  assign fg_rgb = fg_ok ? palette_rgb(unit_i.fg_idx[PAL_IDX_W-1:0]) : '0;
  assign bg_rgb = bg_ok ? palette_rgb(unit_i.bg_idx[PAL_IDX_W-1:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      unit_q   <= unit_i;
      fg_ok_q  <= fg_ok;
      bg_ok_q  <= bg_ok;
      fg_rgb_q <= fg_rgb;
      bg_rgb_q <= bg_rgb;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.text_unit    = unit_q.text_unit;
  assign out_o.is_visible   = unit_q.is_visible;
  assign out_o.message_done = unit_q.message_done;
  assign out_o.bold_on      = unit_q.style[ST_BOLD];
  assign out_o.italic_on    = unit_q.style[ST_ITALIC];
  assign out_o.underline_on = unit_q.style[ST_UNDERLINE];
  assign out_o.strike_on    = unit_q.style[ST_STRIKE];
  assign out_o.mono_on      = unit_q.style[ST_MONO];
  assign out_o.fore_valid   = fg_ok_q;
  assign out_o.fore_rgb     = fg_rgb_q;
  assign out_o.back_valid   = bg_ok_q;
  assign out_o.back_rgb     = bg_rgb_q;

endmodule

// File: rtl/irc_format_code_decoder_unit.sv
// IRC format code decoder: takes one UTF-16 code unit per cycle and gives one
// result per unit, either the visible unit with its style and palette colors or
// a control marker. A unit is accepted every cycle while the output side keeps
// up; its result is written to the FIFO, then to the output register, and is
// held there until taken. The parser holds the only loop-carried state and
// resolves each unit combinationally; a QueueDepth-entry FIFO and an output
// register let either side stall alone.
// Depends on ifcd_pkg, ifcd_in_if, ifcd_out_if, ifcd_front, ifcd_queue, ifcd_back.
module irc_format_code_decoder_unit #(
  parameter int unsigned QueueDepth = ifcd_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifcd_in_if.sink    in_i,
  ifcd_out_if.source out_o
);
  import ifcd_pkg::*;

  logic  space, push, pop, avail;
  unit_t front_unit, queue_unit;

  ifcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push),
    .unit_o  (front_unit)
  );

  ifcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .unit_i  (front_unit),
    .space_o (space),
    .pop_i   (pop),
    .avail_o (avail),
    .unit_o  (queue_unit)
  );

  ifcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .unit_i  (queue_unit),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for irc_format_code_decoder_unit: streams IRC messages in,
// predicts each styled result in SV and compares it against the output channel.
// Depends on ifcd_pkg, ifcd_in_if, ifcd_out_if and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ifcd_pkg::*;

  localparam int unsigned N_UNITS     = 1500;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned DRAIN_TAIL  = 10;

  // palette packed with entry 0 in the low bits
  localparam logic [PALETTE_ENTRIES*RGB_W-1:0] RGB_LUT = {
    24'hD2D2D2, 24'h7F7F7F, 24'hFF00FF, 24'h0000FC,
    24'h00FFFF, 24'h009393, 24'h00FC00, 24'hFFFF00,
    24'hFC7F00, 24'h9C009C, 24'h7F0000, 24'hFF0000,
    24'h009300, 24'h00007F, 24'h000000, 24'hFFFFFF
  };

  typedef struct packed {
    logic [TEXT_W-1:0] cu;
    logic              eom;
  } code_item_t;

  typedef struct packed {
    logic [TEXT_W-1:0] text_unit;
    logic              is_visible;
    logic              message_done;
    logic              bold_on;
    logic              italic_on;
    logic              underline_on;
    logic              strike_on;
    logic              mono_on;
    logic              fore_valid;
    logic [RGB_W-1:0]  fore_rgb;
    logic              back_valid;
    logic [RGB_W-1:0]  back_rgb;
  } styled_unit_t;

  logic clk;
  logic rst_n;

  ifcd_in_if  text_ch ();
  ifcd_out_if styled_ch ();

  irc_format_code_decoder_unit DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (text_ch),
    .out_o (styled_ch)
  );

  code_item_t   unit_q[$];
  styled_unit_t decoded_q[$];
  int unsigned  bad_count;
  int unsigned  idle_cycles;

  // decoder state as seen by the predictor
  logic [STYLE_W-1:0] style_bits;
  logic [IDX_W-1:0]   fg_idx;
  logic [IDX_W-1:0]   bg_idx;
  logic [IDX_W-1:0]   pend_fg;
  logic [IDX_W-1:0]   pend_bg;
  phase_e             color_phase;

  function automatic void clear_decoder();
    style_bits  = '0;
    fg_idx      = NO_INDEX;
    bg_idx      = NO_INDEX;
    pend_fg     = NO_INDEX;
    pend_bg     = NO_INDEX;
    color_phase = PH_PLAIN;
  endfunction

  function automatic void apply_color();
    fg_idx = pend_fg;
    if (pend_bg != NO_INDEX) begin
      bg_idx = pend_bg;
    end
    pend_fg     = NO_INDEX;
    pend_bg     = NO_INDEX;
    color_phase = PH_PLAIN;
  endfunction

  function automatic styled_unit_t decode_unit(logic [TEXT_W-1:0] cu, logic eom);
    styled_unit_t     r;
    logic             taken;
    logic             shown;
    logic             is_dig;
    logic [IDX_W-1:0] dval;
    logic [IDX_W-1:0] eff_fg;
    logic [IDX_W-1:0] eff_bg;
    taken  = 1'b0;
    shown  = 1'b0;
    is_dig = (cu >= CU_DIGIT_0) && (cu <= CU_DIGIT_9);
    dval   = IDX_W'(cu - CU_DIGIT_0);
    case (color_phase)
      PH_START: begin
        if (is_dig) begin
          pend_fg     = dval;
          color_phase = PH_FG1;
          taken       = 1'b1;
        end else begin
          // bare color code clears both colors
          fg_idx      = NO_INDEX;
          bg_idx      = NO_INDEX;
          color_phase = PH_PLAIN;
        end
      end
      PH_FG1: begin
        if (is_dig) begin
          pend_fg     = IDX_W'(pend_fg * 10 + dval);
          color_phase = PH_FG2;
          taken       = 1'b1;
        end else if (cu == CU_COMMA) begin
          color_phase = PH_COMMA;
          taken       = 1'b1;
        end else begin
          apply_color();
        end
      end
      PH_FG2: begin
        if (cu == CU_COMMA) begin
          color_phase = PH_COMMA;
          taken       = 1'b1;
        end else begin
          apply_color();
        end
      end
      PH_COMMA: begin
        if (is_dig) begin
          pend_bg     = dval;
          color_phase = PH_BG1;
          taken       = 1'b1;
        end else begin
          apply_color();
        end
      end
      PH_BG1: begin
        if (is_dig) begin
          pend_bg = IDX_W'(pend_bg * 10 + dval);
          taken   = 1'b1;
        end
        apply_color();
      end
      default: color_phase = PH_PLAIN;
    endcase

    if (!taken) begin
      case (cu)
        CU_BOLD:      style_bits[ST_BOLD]      = ~style_bits[ST_BOLD];
        CU_ITALIC:    style_bits[ST_ITALIC]    = ~style_bits[ST_ITALIC];
        CU_UNDERLINE: style_bits[ST_UNDERLINE] = ~style_bits[ST_UNDERLINE];
        CU_STRIKE:    style_bits[ST_STRIKE]    = ~style_bits[ST_STRIKE];
        CU_MONO:      style_bits[ST_MONO]      = ~style_bits[ST_MONO];
        CU_REVERSE:   style_bits[ST_REVERSE]   = ~style_bits[ST_REVERSE];
        CU_RESET: begin
          style_bits = '0;
          fg_idx     = NO_INDEX;
          bg_idx     = NO_INDEX;
        end
        CU_COLOR: begin
          color_phase = PH_START;
          pend_fg     = NO_INDEX;
          pend_bg     = NO_INDEX;
        end
        default: shown = 1'b1;
      endcase
    end

    r = '0;
    r.message_done = eom;
    if (shown) begin
      eff_fg         = style_bits[ST_REVERSE] ? bg_idx : fg_idx;
      eff_bg         = style_bits[ST_REVERSE] ? fg_idx : bg_idx;
      r.text_unit    = cu;
      r.is_visible   = 1'b1;
      r.bold_on      = style_bits[ST_BOLD];
      r.italic_on    = style_bits[ST_ITALIC];
      r.underline_on = style_bits[ST_UNDERLINE];
      r.strike_on    = style_bits[ST_STRIKE];
      r.mono_on      = style_bits[ST_MONO];
      if (eff_fg < PALETTE_ENTRIES) begin
        r.fore_valid = 1'b1;
        r.fore_rgb   = RGB_LUT[eff_fg[PAL_IDX_W-1:0]*RGB_W +: RGB_W];
      end
      if (eff_bg < PALETTE_ENTRIES) begin
        r.back_valid = 1'b1;
        r.back_rgb   = RGB_LUT[eff_bg[PAL_IDX_W-1:0]*RGB_W +: RGB_W];
      end
    end
    if (eom) begin
      clear_decoder();
    end
    return r;
  endfunction

  task automatic push_unit(input logic [TEXT_W-1:0] cu, input logic eom = 1'b0);
    code_item_t it;
    it.cu  = cu;
    it.eom = eom;
    unit_q.push_back(it);
  endtask

  // mostly 0/1 so that many indices land inside the palette
  function automatic logic [TEXT_W-1:0] rand_digit();
    if ($urandom_range(0, 2) == 0) begin
      return CU_DIGIT_0 + TEXT_W'($urandom_range(0, 9));
    end
    return CU_DIGIT_0 + TEXT_W'($urandom_range(0, 1));
  endfunction

  task automatic check_field(input string name, input logic [RGB_W-1:0] want,
                             input logic [RGB_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      bad_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------- driver ----------------
  int unsigned burst_left;
  int unsigned gap_left;
  code_item_t  next_item;

  initial begin
    text_ch.valid          = 1'b0;
    text_ch.code_unit      = '0;
    text_ch.end_of_message = 1'b0;
    styled_ch.ready        = 1'b0;
    burst_left             = 1;
    gap_left               = 0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        decoded_q.push_back(decode_unit(text_ch.code_unit, text_ch.end_of_message));
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          text_ch.valid <= 1'b0;
        end else if (unit_q.size() > 0) begin
          next_item = unit_q.pop_front();
          text_ch.valid          <= 1'b1;
          text_ch.code_unit      <= next_item.cu;
          text_ch.end_of_message <= next_item.eom;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(5, 12);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall pattern ----------------
  int unsigned    mode_left;
  int unsigned    stall_mode;
  int unsigned    slow_cnt;
  logic [7:0]     ready_pat;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      styled_ch.ready <= 1'b0;
      mode_left  = 0;
      stall_mode = 0;
      slow_cnt   = 0;
      ready_pat  = 8'hFF;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(20, 200);
        stall_mode = $urandom_range(0, 3);
        ready_pat  = 8'($urandom) | 8'h01;
      end
      mode_left--;
      case (stall_mode)
        0: styled_ch.ready <= 1'b1;
        1: styled_ch.ready <= 1'($urandom);
        2: begin
          styled_ch.ready <= ready_pat[0];
          ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
        default: begin
          // slow consumer: ready only when the wrapping slow_cnt counter returns to zero
          slow_cnt = (slow_cnt + 1) % 6;
          styled_ch.ready <= (slow_cnt == 0);
        end
      endcase
    end
  end

  // ---------------- monitor ----------------
  styled_unit_t want_unit;
  styled_unit_t got_unit;

  always @(posedge clk) begin
    if (rst_n && styled_ch.valid && styled_ch.ready) begin
      got_unit.text_unit    = styled_ch.text_unit;
      got_unit.is_visible   = styled_ch.is_visible;
      got_unit.message_done = styled_ch.message_done;
      got_unit.bold_on      = styled_ch.bold_on;
      got_unit.italic_on    = styled_ch.italic_on;
      got_unit.underline_on = styled_ch.underline_on;
      got_unit.strike_on    = styled_ch.strike_on;
      got_unit.mono_on      = styled_ch.mono_on;
      got_unit.fore_valid   = styled_ch.fore_valid;
      got_unit.fore_rgb     = styled_ch.fore_rgb;
      got_unit.back_valid   = styled_ch.back_valid;
      got_unit.back_rgb     = styled_ch.back_rgb;
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual text_unit %0h",
                 $time, got_unit.text_unit);
        bad_count++;
      end else begin
        want_unit = decoded_q.pop_front();
        check_field("text_unit",    want_unit.text_unit,    got_unit.text_unit);
        check_field("is_visible",   want_unit.is_visible,   got_unit.is_visible);
        check_field("message_done", want_unit.message_done, got_unit.message_done);
        check_field("bold_on",      want_unit.bold_on,      got_unit.bold_on);
        check_field("italic_on",    want_unit.italic_on,    got_unit.italic_on);
        check_field("underline_on", want_unit.underline_on, got_unit.underline_on);
        check_field("strike_on",    want_unit.strike_on,    got_unit.strike_on);
        check_field("mono_on",      want_unit.mono_on,      got_unit.mono_on);
        check_field("fore_valid",   want_unit.fore_valid,   got_unit.fore_valid);
        check_field("fore_rgb",     want_unit.fore_rgb,     got_unit.fore_rgb);
        check_field("back_valid",   want_unit.back_valid,   got_unit.back_valid);
        check_field("back_rgb",     want_unit.back_rgb,     got_unit.back_rgb);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst_n || (text_ch.valid && text_ch.ready) ||
        (styled_ch.valid && styled_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin : stimulus
    code_item_t  msg_q[$];
    int unsigned n_seg;
    int unsigned n_dig;
    int unsigned sel;
    int unsigned k;
    int unsigned j;
    code_item_t  it;

    bad_count   = 0;
    idle_cycles = 0;
    clear_decoder();

    // extremes of the code unit, then every style toggle
    push_unit(16'h0000);
    push_unit(16'hFFFF);
    push_unit(CU_BOLD);
    push_unit(CU_ITALIC);
    push_unit(CU_UNDERLINE);
    push_unit(CU_STRIKE);
    push_unit(CU_MONO);
    push_unit(CU_REVERSE);
    // full fg,bg sequence closed by its third digit, shown reversed
    push_unit(CU_COLOR);
    push_unit(CU_DIGIT_0 + 16'd4);
    push_unit(CU_COMMA);
    push_unit(CU_DIGIT_0 + 16'd1);
    push_unit(CU_DIGIT_0 + 16'd2);
    push_unit(16'h0078);
    // bare color code: comma right after it stays visible
    push_unit(CU_COLOR);
    push_unit(CU_COMMA);
    // third digit in a row is text
    push_unit(CU_COLOR);
    push_unit(CU_DIGIT_0 + 16'd1);
    push_unit(CU_DIGIT_0 + 16'd2);
    push_unit(CU_DIGIT_0 + 16'd3);
    // index beyond the palette, comma with no bg digits, non-ASCII digit ends it
    push_unit(CU_COLOR);
    push_unit(CU_DIGIT_9);
    push_unit(CU_DIGIT_9);
    push_unit(CU_COMMA);
    push_unit(16'h0660);
    push_unit(CU_RESET);
    // message ends inside a color sequence
    push_unit(CU_COLOR);
    push_unit(CU_DIGIT_0 + 16'd5, 1'b1);
    push_unit(16'h0041, 1'b1);

    while (unit_q.size() < N_UNITS) begin
      msg_q.delete();
      n_seg = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 8);
      for (k = 0; k < n_seg; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          it = '0;
          it.cu = CU_COLOR;
          msg_q.push_back(it);
          n_dig = $urandom_range(0, 3);
          for (j = 0; j < n_dig; j++) begin
            it.cu = rand_digit();
            msg_q.push_back(it);
          end
          if ($urandom_range(0, 2) != 0) begin
            it.cu = CU_COMMA;
            msg_q.push_back(it);
            n_dig = $urandom_range(0, 3);
            for (j = 0; j < n_dig; j++) begin
              it.cu = rand_digit();
              msg_q.push_back(it);
            end
          end
        end else if (sel < 50) begin
          it = '0;
          case ($urandom_range(0, 7))
            0: it.cu = CU_BOLD;
            1: it.cu = CU_ITALIC;
            2: it.cu = CU_UNDERLINE;
            3: it.cu = CU_STRIKE;
            4: it.cu = CU_MONO;
            5: it.cu = CU_REVERSE;
            6: it.cu = CU_RESET;
            default: it.cu = CU_COLOR;
          endcase
          msg_q.push_back(it);
        end else if (sel < 85) begin
          n_dig = $urandom_range(1, 4);
          for (j = 0; j < n_dig; j++) begin
            it = '0;
            it.cu = TEXT_W'($urandom_range(16'h20, 16'h7E));
            msg_q.push_back(it);
          end
        end else if (sel < 95) begin
          it = '0;
          it.cu = TEXT_W'($urandom);
          msg_q.push_back(it);
        end else begin
          it = '0;
          it.cu = $urandom_range(0, 1) ? CU_COMMA : rand_digit();
          msg_q.push_back(it);
        end
      end
      msg_q[msg_q.size()-1].eom = 1'b1;
      foreach (msg_q[i]) begin
        unit_q.push_back(msg_q[i]);
      end
    end

    @(posedge rst_n);
    while (unit_q.size() != 0 || text_ch.valid || decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (bad_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: irc_format_code_decoder_unit.f
rtl/ifcd_pkg.sv
rtl/ifcd_in_if.sv
rtl/ifcd_out_if.sv
rtl/ifcd_front.sv
rtl/ifcd_queue.sv
rtl/ifcd_back.sv
rtl/irc_format_code_decoder_unit.sv
bench/tb_top.sv
